// ===== hw/rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// Used by pls_cell and positional_list_store_unit; no dependencies.
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;  // entry_count field width
  localparam int POS_W    = 5;  // position field width
  localparam int CMD_W    = 3;

  localparam int IN_TDATA_W  = 40;  // 3 + 32 + 5, already whole bytes
  localparam int OUT_TDATA_W = 40;  // 1 + 32 + 5 = 38, padded to 40

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DROP   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // The operation that every cell performs.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [DATA_W-1:0]      value;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pls_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list: holds one entry, takes from its left or
// right neighbor, loads a new value, or holds. Depends on pls_pkg.
module pls_cell (
  input  logic                       clk_i,
  input  pls_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pls_pkg::IDX_W-1:0]  idx_i,
  input  logic [pls_pkg::DATA_W-1:0] left_i,
  input  logic [pls_pkg::DATA_W-1:0] right_i,
  output logic [pls_pkg::DATA_W-1:0] data_o,
  output logic [pls_pkg::DATA_W-1:0] rd_o
);
  import pls_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]  my_pos;

  assign my_pos = POS_W'(idx_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (my_pos == POS_W'(ctrl_i.count)) data_d = ctrl_i.value;
      end
      OP_INSERT: begin
        if (my_pos == ctrl_i.pos) data_d = ctrl_i.value;
        else if (my_pos > ctrl_i.pos) data_d = left_i;
      end
      OP_REMOVE: begin
        if (my_pos >= ctrl_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the entry onto the read bus only when addressed.
  assign rd_o   = (my_pos == ctrl_i.pos) ? data_q : '0;

endmodule

// ===== hw/rtl/positional_list_store_unit.sv =====
`timescale 1ns / 1ps
// Positional list store: a bounded ordered list of up to 16 signed 32-bit
// entries kept in a row of cells, each cell holding one entry. For every
// command (append, insert at position, drop tail, remove at position, read
// at position) all cells decide in the same cycle whether to load, take
// from a neighbor or hold, so one command transfer is accepted every clock
// unless the output is stalled; its result goes to the output register.
// A waiting result blocks new commands only while the output is stalled.
// Entries above the count are never read; cells carry no reset.
// Depends on pls_pkg and pls_cell.
module positional_list_store_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command[2:0], value[34:3], position[39:35]
  input  logic [pls_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // status[0], read_data[32:1], entry_count[37:33], zero pad [39:38]
  output logic [pls_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);
  import pls_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // Unpack the command transfer.
  logic [CMD_W-1:0]  in_cmd;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;

  assign in_cmd   = s_axis_tdata_i[CMD_W-1:0];
  assign in_value = s_axis_tdata_i[CMD_W+DATA_W-1:CMD_W];
  assign in_pos   = s_axis_tdata_i[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W];

  logic              accept;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              out_status_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              cmd_ok;
  logic [DATA_W-1:0] rd_data;
  cell_op_e          cmd_op;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_bus;

  // Accept a new command whenever the output register is free or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Decode the command against the current count.
  always_comb begin
    cmd_ok  = 1'b0;
    cmd_op  = OP_HOLD;
    count_d = count_q;
    rd_data = '0;
    case (in_cmd)
      CMD_APPEND: begin
        if (count_q < FULL_CNT) begin
          cmd_ok  = 1'b1;
          cmd_op  = OP_APPEND;
          count_d = count_q + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (in_pos <= count_q && count_q < FULL_CNT) begin
          cmd_ok  = 1'b1;
          cmd_op  = OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CMD_DROP: begin
        if (count_q != '0) begin
          cmd_ok  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (in_pos < count_q) begin
          cmd_ok  = 1'b1;
          cmd_op  = OP_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (in_pos < count_q) begin
          cmd_ok  = 1'b1;
          rd_data = rd_bus;
        end
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  // Broadcast control to all cells; hold them unless a command transfers.
  always_comb begin
    ctrl.op    = accept ? cmd_op : OP_HOLD;
    ctrl.value = in_value;
    ctrl.pos   = in_pos;
    ctrl.count = count_q;
  end

  // Row of cells; each takes from its neighbors. Ends see zero.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Only the addressed cell drives nonzero; merge by OR.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // Count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_rdata_q  <= '0;
      out_count_q  <= '0;
    end else begin
      if (accept) begin
        count_q      <= count_d;
        out_valid_q  <= 1'b1;
        out_status_q <= !cmd_ok;
        out_rdata_q  <= rd_data;
        out_count_q  <= count_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 1 - DATA_W - CNT_W)'(0),
                            out_count_q, out_rdata_q, out_status_q};

endmodule
